// ===== rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg: terminal line editor shared definitions
// Byte codes, phase and outcome codes, and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

  // line store geometry
  localparam int LINE_BYTES = 32;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);
  localparam int CAP_W      = 6;

  // capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(LINE_BYTES);

  // byte codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_DEL      = 8'h7f;

  // input kinds
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_SILENCE = 1'b1;

  // result channel and outcome codes
  localparam logic       CHAN_ECHO   = 1'b0;
  localparam logic       CHAN_LINE   = 1'b1;
  localparam logic [1:0] OUT_EDIT    = 2'd0;
  localparam logic [1:0] OUT_ACCEPT  = 2'd1;
  localparam logic [1:0] OUT_ABORT   = 2'd2;

  // escape phase codes
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD   = 3'd0,
    IDX_ZERO   = 3'd1,
    IDX_LEN    = 3'd2,
    IDX_CUR    = 3'd3,
    IDX_CUR_P1 = 3'd4,
    IDX_INC    = 3'd5,
    IDX_DEC    = 3'd6
  } idx_op_t;

  typedef enum logic [1:0] {
    ADDR_IDX    = 2'd0,
    ADDR_IDX_M1 = 2'd1,
    ADDR_CUR    = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    EMIT_CONST  = 2'd0,
    EMIT_RDATA  = 2'd1,
    EMIT_INBYTE = 2'd2
  } emit_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       rd;
    logic       wr;
    addr_sel_t  addr_sel;
    logic       wr_inbyte;
    idx_op_t    idx_op;
    cnt_op_t    len_op;
    cnt_op_t    cur_op;
    logic       esc_load;
    logic [1:0] esc_val;
    logic       emit;
    emit_sel_t  emit_sel;
    logic [7:0] emit_const;
    logic       emit_chan;
    logic [1:0] emit_outcome;
    logic       emit_last;
  } tle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] esc;
    logic       idx_lt_len;
    logic       idx_eq_len;
    logic       idx_p1_eq_len;
    logic       idx_gt_cur;
    logic       cur_p1_eq_len;
    logic       cur_lt_len;
    logic       cur_nz;
    logic       full;
    logic       out_free;
  } tle_status_t;

endpackage

// ===== rtl/tle_dp.sv =====
// ----------------------------------------------------------------------------
// tle_dp: terminal line editor datapath
// Line store, length, cursor, escape phase, walk index, capacity register
// and the result register.
// ----------------------------------------------------------------------------
module tle_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  tle_pkg::tle_cmd_t         cmd,
  output tle_pkg::tle_status_t      stat,
  input  logic [7:0]                byte_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tle_pkg::CAP_W-1:0] capacity,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      channel,
  output logic [1:0]                outcome,
  output logic                      last
);

  logic [7:0]                  mem [tle_pkg::LINE_BYTES];
  logic [7:0]                  rdata;
  logic [7:0]                  in_byte;
  logic [tle_pkg::CNT_W-1:0]   len;
  logic [tle_pkg::CNT_W-1:0]   cur;
  logic [tle_pkg::CNT_W-1:0]   idx;
  logic [tle_pkg::CNT_W-1:0]   idx_next;
  logic [tle_pkg::CNT_W-1:0]   idx_m1;
  logic [tle_pkg::CNT_W-1:0]   idx_p1;
  logic [tle_pkg::CNT_W-1:0]   cur_p1;
  logic [1:0]                  esc;
  logic [tle_pkg::CAP_W-1:0]   cap;
  logic [tle_pkg::CAP_W-1:0]   cap_eff;
  logic [tle_pkg::ADDR_W-1:0]  addr;
  logic [7:0]                  wdata;
  logic [7:0]                  emit_byte;
  logic                        out_free;

  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= tle_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= capacity;
    end
  end

  // effective capacity saturates into the supported range
  always_comb begin
    if (cap < tle_pkg::CAP_MIN) begin
      cap_eff = tle_pkg::CAP_MIN;
    end else if (cap > tle_pkg::CAP_MAX) begin
      cap_eff = tle_pkg::CAP_MAX;
    end else begin
      cap_eff = cap;
    end
  end

  assign idx_m1 = idx - tle_pkg::CNT_W'(1);
  assign idx_p1 = idx + tle_pkg::CNT_W'(1);
  assign cur_p1 = cur + tle_pkg::CNT_W'(1);

  // line store address and write data
  always_comb begin
    case (cmd.addr_sel)
      tle_pkg::ADDR_IDX:    addr = idx[tle_pkg::ADDR_W-1:0];
      tle_pkg::ADDR_IDX_M1: addr = idx_m1[tle_pkg::ADDR_W-1:0];
      tle_pkg::ADDR_CUR:    addr = cur[tle_pkg::ADDR_W-1:0];
      default:              addr = idx[tle_pkg::ADDR_W-1:0];
    endcase
  end

  assign wdata = cmd.wr_inbyte ? in_byte : rdata;

  // single port line store with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  // latched input byte
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_byte <= byte_value;
    end
  end

  // walk index
  always_comb begin
    case (cmd.idx_op)
      tle_pkg::IDX_HOLD:   idx_next = idx;
      tle_pkg::IDX_ZERO:   idx_next = '0;
      tle_pkg::IDX_LEN:    idx_next = len;
      tle_pkg::IDX_CUR:    idx_next = cur;
      tle_pkg::IDX_CUR_P1: idx_next = cur_p1;
      tle_pkg::IDX_INC:    idx_next = idx_p1;
      tle_pkg::IDX_DEC:    idx_next = idx_m1;
      default:             idx_next = idx;
    endcase
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      len <= '0;
      cur <= '0;
      esc <= tle_pkg::ESC_IDLE;
    end else begin
      idx <= idx_next;
      case (cmd.len_op)
        tle_pkg::CNT_INC: len <= len + tle_pkg::CNT_W'(1);
        tle_pkg::CNT_DEC: len <= len - tle_pkg::CNT_W'(1);
        tle_pkg::CNT_CLR: len <= '0;
        default:          len <= len;
      endcase
      case (cmd.cur_op)
        tle_pkg::CNT_INC: cur <= cur_p1;
        tle_pkg::CNT_DEC: cur <= cur - tle_pkg::CNT_W'(1);
        tle_pkg::CNT_CLR: cur <= '0;
        default:          cur <= cur;
      endcase
      if (cmd.esc_load) begin
        esc <= cmd.esc_val;
      end
    end
  end

  // result byte selection
  always_comb begin
    case (cmd.emit_sel)
      tle_pkg::EMIT_CONST:  emit_byte = cmd.emit_const;
      tle_pkg::EMIT_RDATA:  emit_byte = rdata;
      tle_pkg::EMIT_INBYTE: emit_byte = in_byte;
      default:              emit_byte = cmd.emit_const;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= emit_byte;
      channel  <= cmd.emit_chan;
      outcome  <= cmd.emit_outcome;
      last     <= cmd.emit_last;
    end
  end

  // status to the controller
  always_comb begin
    stat.esc           = esc;
    stat.idx_lt_len    = idx < len;
    stat.idx_eq_len    = idx == len;
    stat.idx_p1_eq_len = idx_p1 == len;
    stat.idx_gt_cur    = idx > cur;
    stat.cur_p1_eq_len = cur_p1 == len;
    stat.cur_lt_len    = cur < len;
    stat.cur_nz        = cur != '0;
    stat.full          = tle_pkg::CAP_W'(len) >= (cap_eff - tle_pkg::CAP_W'(1));
    stat.out_free      = out_free;
  end

  // checks
  a_cur_within_line: assert property (@(posedge clk) disable iff (rst)
    cur <= len)
    else $error("cursor beyond end of line");

  a_len_bounded: assert property (@(posedge clk) disable iff (rst)
    len <= tle_pkg::CNT_W'(tle_pkg::LINE_BYTES - 1))
    else $error("line length beyond store");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result written over a held result");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> !cmd.rd)
    else $error("line store read and written together");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last && (cmd.emit_outcome != tle_pkg::OUT_EDIT))
    |=> (len == '0 && cur == '0 && esc == tle_pkg::ESC_IDLE))
    else $error("line not cleared after accept or abort");

endmodule

// ===== rtl/tle_ctrl.sv =====
// ----------------------------------------------------------------------------
// tle_ctrl: terminal line editor controller
// Decodes each accepted transaction and sequences the store moves and the
// result bytes one step at a time.
// ----------------------------------------------------------------------------
module tle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [7:0]            byte_value,
  input  tle_pkg::tle_status_t  stat,
  output tle_pkg::tle_cmd_t     cmd
);

  typedef enum logic [18:0] {
    ST_IDLE    = 19'd1,
    ST_ISH     = 19'd2,
    ST_ISH_WR  = 19'd4,
    ST_INS_WR  = 19'd8,
    ST_BSH     = 19'd16,
    ST_BSH_WR  = 19'd32,
    ST_BS_HEAD = 19'd64,
    ST_TAIL_RD = 19'd128,
    ST_TAIL_EM = 19'd256,
    ST_SPACE   = 19'd512,
    ST_BS_RUN  = 19'd1024,
    ST_NL      = 19'd2048,
    ST_LINE_RD = 19'd4096,
    ST_LINE_EM = 19'd8192,
    ST_TERM    = 19'd16384,
    ST_ABORT   = 19'd32768,
    ST_ARW0    = 19'd65536,
    ST_ARW1    = 19'd131072,
    ST_ARW2    = 19'd262144
  } state_t;

  state_t state;
  state_t state_next;
  logic   ins_mode;
  logic   ins_mode_next;
  logic   sil;
  logic   bs_more;

  assign in_stall = (state != ST_IDLE);
  assign sil      = (op == tle_pkg::OP_SILENCE);
  assign bs_more  = stat.idx_lt_len || (!ins_mode && stat.idx_eq_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ins_mode <= 1'b0;
    end else begin
      state    <= state_next;
      ins_mode <= ins_mode_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    ins_mode_next = ins_mode;
    case (state)
      // decode the incoming transaction
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.esc == tle_pkg::ESC_SEEN) begin
            if (!sil && byte_value == tle_pkg::CH_LBRACKET) begin
              cmd.esc_load = 1'b1;
              cmd.esc_val  = tle_pkg::ESC_CSI;
            end else begin
              state_next = ST_ABORT;
            end
          end else if (stat.esc == tle_pkg::ESC_CSI) begin
            cmd.esc_load = 1'b1;
            cmd.esc_val  = tle_pkg::ESC_IDLE;
            if (!sil && byte_value == tle_pkg::CH_C && stat.cur_lt_len) begin
              cmd.cur_op = tle_pkg::CNT_INC;
              state_next = ST_ARW0;
            end else if (!sil && byte_value == tle_pkg::CH_D && stat.cur_nz) begin
              cmd.cur_op = tle_pkg::CNT_DEC;
              state_next = ST_ARW0;
            end
          end else if (sil) begin
            cmd.idx_op = tle_pkg::IDX_ZERO;
            state_next = ST_LINE_RD;
          end else if (byte_value == tle_pkg::CH_ESC) begin
            cmd.esc_load = 1'b1;
            cmd.esc_val  = tle_pkg::ESC_SEEN;
          end else if (byte_value == tle_pkg::CH_CR || byte_value == tle_pkg::CH_LF) begin
            state_next = ST_NL;
          end else if (byte_value == tle_pkg::CH_DEL || byte_value == tle_pkg::CH_BS) begin
            if (stat.cur_nz) begin
              cmd.idx_op    = tle_pkg::IDX_CUR;
              ins_mode_next = 1'b0;
              state_next    = ST_BSH;
            end
          end else if (byte_value >= tle_pkg::CH_SPACE && byte_value < tle_pkg::CH_DEL
                       && !stat.full) begin
            cmd.idx_op    = tle_pkg::IDX_LEN;
            ins_mode_next = 1'b1;
            state_next    = ST_ISH;
          end
        end
      end
      // open a gap at the cursor, top entry first
      ST_ISH: begin
        if (stat.idx_gt_cur) begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = tle_pkg::ADDR_IDX_M1;
          state_next   = ST_ISH_WR;
        end else begin
          state_next = ST_INS_WR;
        end
      end
      ST_ISH_WR: begin
        cmd.wr       = 1'b1;
        cmd.addr_sel = tle_pkg::ADDR_IDX;
        cmd.idx_op   = tle_pkg::IDX_DEC;
        state_next   = ST_ISH;
      end
      ST_INS_WR: begin
        cmd.wr        = 1'b1;
        cmd.wr_inbyte = 1'b1;
        cmd.addr_sel  = tle_pkg::ADDR_CUR;
        cmd.len_op    = tle_pkg::CNT_INC;
        cmd.idx_op    = tle_pkg::IDX_CUR;
        state_next    = ST_TAIL_RD;
      end
      // close the gap before the cursor, bottom entry first
      ST_BSH: begin
        if (stat.idx_lt_len) begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = tle_pkg::ADDR_IDX;
          state_next   = ST_BSH_WR;
        end else begin
          cmd.len_op = tle_pkg::CNT_DEC;
          cmd.cur_op = tle_pkg::CNT_DEC;
          state_next = ST_BS_HEAD;
        end
      end
      ST_BSH_WR: begin
        cmd.wr       = 1'b1;
        cmd.addr_sel = tle_pkg::ADDR_IDX_M1;
        cmd.idx_op   = tle_pkg::IDX_INC;
        state_next   = ST_BSH;
      end
      ST_BS_HEAD: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = tle_pkg::EMIT_CONST;
          cmd.emit_const = tle_pkg::CH_BS;
          cmd.idx_op     = tle_pkg::IDX_CUR;
          state_next     = ST_TAIL_RD;
        end
      end
      // echo the tail from the cursor
      ST_TAIL_RD: begin
        if (stat.idx_lt_len) begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = tle_pkg::ADDR_IDX;
          state_next   = ST_TAIL_EM;
        end else if (ins_mode) begin
          cmd.cur_op = tle_pkg::CNT_INC;
          cmd.idx_op = tle_pkg::IDX_CUR_P1;
          state_next = ST_BS_RUN;
        end else begin
          state_next = ST_SPACE;
        end
      end
      ST_TAIL_EM: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tle_pkg::EMIT_RDATA;
          cmd.emit_last = ins_mode && stat.idx_p1_eq_len && stat.cur_p1_eq_len;
          cmd.idx_op    = tle_pkg::IDX_INC;
          state_next    = ST_TAIL_RD;
        end
      end
      ST_SPACE: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = tle_pkg::EMIT_CONST;
          cmd.emit_const = tle_pkg::CH_SPACE;
          cmd.idx_op     = tle_pkg::IDX_CUR;
          state_next     = ST_BS_RUN;
        end
      end
      // walk the terminal cursor back
      ST_BS_RUN: begin
        if (bs_more) begin
          if (stat.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_sel   = tle_pkg::EMIT_CONST;
            cmd.emit_const = tle_pkg::CH_BS;
            cmd.emit_last  = ins_mode ? stat.idx_p1_eq_len : stat.idx_eq_len;
            cmd.idx_op     = tle_pkg::IDX_INC;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      // line accepted
      ST_NL: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = tle_pkg::EMIT_CONST;
          cmd.emit_const   = tle_pkg::CH_LF;
          cmd.emit_chan    = tle_pkg::CHAN_ECHO;
          cmd.emit_outcome = tle_pkg::OUT_ACCEPT;
          cmd.idx_op       = tle_pkg::IDX_ZERO;
          state_next       = ST_LINE_RD;
        end
      end
      ST_LINE_RD: begin
        if (stat.idx_lt_len) begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = tle_pkg::ADDR_IDX;
          state_next   = ST_LINE_EM;
        end else begin
          state_next = ST_TERM;
        end
      end
      ST_LINE_EM: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = tle_pkg::EMIT_RDATA;
          cmd.emit_chan    = tle_pkg::CHAN_LINE;
          cmd.emit_outcome = tle_pkg::OUT_ACCEPT;
          cmd.idx_op       = tle_pkg::IDX_INC;
          state_next       = ST_LINE_RD;
        end
      end
      ST_TERM: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = tle_pkg::EMIT_CONST;
          cmd.emit_const   = tle_pkg::CH_NUL;
          cmd.emit_chan    = tle_pkg::CHAN_LINE;
          cmd.emit_outcome = tle_pkg::OUT_ACCEPT;
          cmd.emit_last    = 1'b1;
          cmd.len_op       = tle_pkg::CNT_CLR;
          cmd.cur_op       = tle_pkg::CNT_CLR;
          cmd.esc_load     = 1'b1;
          cmd.esc_val      = tle_pkg::ESC_IDLE;
          state_next       = ST_IDLE;
        end
      end
      // bare escape aborts the line
      ST_ABORT: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = tle_pkg::EMIT_CONST;
          cmd.emit_const   = tle_pkg::CH_LF;
          cmd.emit_chan    = tle_pkg::CHAN_ECHO;
          cmd.emit_outcome = tle_pkg::OUT_ABORT;
          cmd.emit_last    = 1'b1;
          cmd.len_op       = tle_pkg::CNT_CLR;
          cmd.cur_op       = tle_pkg::CNT_CLR;
          cmd.esc_load     = 1'b1;
          cmd.esc_val      = tle_pkg::ESC_IDLE;
          state_next       = ST_IDLE;
        end
      end
      // arrow echo
      ST_ARW0: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = tle_pkg::EMIT_CONST;
          cmd.emit_const = tle_pkg::CH_ESC;
          state_next     = ST_ARW1;
        end
      end
      ST_ARW1: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = tle_pkg::EMIT_CONST;
          cmd.emit_const = tle_pkg::CH_LBRACKET;
          state_next     = ST_ARW2;
        end
      end
      ST_ARW2: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tle_pkg::EMIT_INBYTE;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor: console line editor with cursor
// Keeps one edit line, echoes redraws and emits the finished line.
// ----------------------------------------------------------------------------
// One transaction is taken at a time: the input stalls until the block is
// idle again. A byte that produces no output (escape start, ignored byte,
// refused insert, unmatched arrow) is handled without leaving idle. Other
// work runs through the single-port line store, which makes one access per
// cycle with a registered read. An insert or a delete reads and writes each
// character moved, reads and emits each tail byte echoed, and emits one
// backspace per step back. A completed arrow key emits ESC, [ and the
// direction byte, an abort a line feed, and an accepted line its characters
// and a zero terminator on the line channel, after a line feed when ended by
// CR or LF. A result is held while the output is stalled. Capacity writes
// are taken at any time and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module terminal_line_editor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [7:0]                byte_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      channel,
  output logic [1:0]                outcome,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tle_pkg::CAP_W-1:0] capacity
);

  tle_pkg::tle_cmd_t    cmd;
  tle_pkg::tle_status_t stat;

  // sequencing
  tle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .byte_value (byte_value),
    .stat       (stat),
    .cmd        (cmd)
  );

  // storage and result register
  tle_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .byte_value (byte_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .channel    (channel),
    .outcome    (outcome),
    .last       (last)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the terminal line editor
// Drives console bytes and silence events with random gaps, stalls the
// result side at random and compares every echo and line byte against a
// cycle-free model of the editor. Capacity is rewritten between phases,
// including out-of-range settings and values below the current line length.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_TARGET   = 470;
  localparam int MAX_PER_KEY   = 63;

  typedef struct packed {
    logic [7:0] data;
    logic       chan;
    logic [1:0] oc;
    logic       lst;
  } edit_result_t;

  // model of the editor and store of the output bytes it predicts
  class redraw_tracker;
    logic [7:0]   text [tle_pkg::LINE_BYTES];
    int           len;
    int           cur;
    logic [1:0]   phase;
    logic [5:0]   cap_reg;
    int           step_count;
    int           mismatches;
    edit_result_t expected_echo [$];

    function new();
      len        = 0;
      cur        = 0;
      phase      = tle_pkg::ESC_IDLE;
      cap_reg    = tle_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    function void set_capacity(logic [5:0] v);
      cap_reg = v;
    endfunction

    function int outstanding();
      return expected_echo.size();
    endfunction

    function void push_result(logic [7:0] b, logic ch, logic [1:0] oc);
      edit_result_t r;
      if (step_count >= MAX_PER_KEY) return;
      r.data = b;
      r.chan = ch;
      r.oc   = oc;
      r.lst  = 1'b0;
      expected_echo.push_back(r);
      step_count++;
    endfunction

    function void clear_line();
      len   = 0;
      cur   = 0;
      phase = tle_pkg::ESC_IDLE;
    endfunction

    function void push_arrow_echo(logic [7:0] dir);
      push_result(tle_pkg::CH_ESC, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      push_result(tle_pkg::CH_LBRACKET, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      push_result(dir, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
    endfunction

    // finished line goes out on the line channel with a zero terminator
    function void accept_line(bit with_newline);
      if (with_newline) push_result(tle_pkg::CH_LF, tle_pkg::CHAN_ECHO, tle_pkg::OUT_ACCEPT);
      for (int i = 0; i < len; i++)
        push_result(text[i], tle_pkg::CHAN_LINE, tle_pkg::OUT_ACCEPT);
      push_result(tle_pkg::CH_NUL, tle_pkg::CHAN_LINE, tle_pkg::OUT_ACCEPT);
      clear_line();
    endfunction

    // delete before the cursor, redraw tail, blank the old end, step back
    function void erase_left();
      if (cur == 0) return;
      for (int i = cur; i < len; i++) text[i-1] = text[i];
      len--;
      cur--;
      push_result(tle_pkg::CH_BS, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      for (int i = cur; i < len; i++)
        push_result(text[i], tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      push_result(tle_pkg::CH_SPACE, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      for (int i = cur; i <= len; i++)
        push_result(tle_pkg::CH_BS, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
    endfunction

    // insert at the cursor, echo the tail and back up over it
    function void insert_char(logic [7:0] c);
      int eff;
      eff = cap_reg;
      if (eff < tle_pkg::CAP_MIN) eff = tle_pkg::CAP_MIN;
      if (eff > tle_pkg::CAP_MAX) eff = tle_pkg::CAP_MAX;
      if (c < tle_pkg::CH_SPACE || c >= tle_pkg::CH_DEL || len >= eff - 1) return;
      for (int i = len; i > cur; i--) text[i] = text[i-1];
      text[cur] = c;
      len++;
      for (int i = cur; i < len; i++)
        push_result(text[i], tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
      cur++;
      for (int i = cur; i < len; i++)
        push_result(tle_pkg::CH_BS, tle_pkg::CHAN_ECHO, tle_pkg::OUT_EDIT);
    endfunction

    function void take_keystroke(logic silent, logic [7:0] c);
      int first;
      first      = expected_echo.size();
      step_count = 0;
      if (phase == tle_pkg::ESC_SEEN) begin
        if (!silent && c == tle_pkg::CH_LBRACKET) begin
          phase = tle_pkg::ESC_CSI;
        end else begin
          push_result(tle_pkg::CH_LF, tle_pkg::CHAN_ECHO, tle_pkg::OUT_ABORT);
          clear_line();
        end
      end else if (phase == tle_pkg::ESC_CSI) begin
        phase = tle_pkg::ESC_IDLE;
        if (!silent && c == tle_pkg::CH_C && cur < len) begin
          cur++;
          push_arrow_echo(tle_pkg::CH_C);
        end else if (!silent && c == tle_pkg::CH_D && cur > 0) begin
          cur--;
          push_arrow_echo(tle_pkg::CH_D);
        end
      end else if (silent) begin
        accept_line(1'b0);
      end else if (c == tle_pkg::CH_ESC) begin
        phase = tle_pkg::ESC_SEEN;
      end else if (c == tle_pkg::CH_CR || c == tle_pkg::CH_LF) begin
        accept_line(1'b1);
      end else if (c == tle_pkg::CH_DEL || c == tle_pkg::CH_BS) begin
        erase_left();
      end else begin
        insert_char(c);
      end
      if (expected_echo.size() > first) expected_echo[$].lst = 1'b1;
    endfunction

    task check_echo(logic [7:0] b, logic ch, logic [1:0] oc, logic lst);
      edit_result_t want;
      if (expected_echo.size() == 0) begin
        report($sformatf("output byte %02h channel %0d with nothing pending", b, ch));
        return;
      end
      want = expected_echo.pop_front();
      if (b !== want.data)
        report($sformatf("out_byte %02h, predicted %02h", b, want.data));
      if (ch !== want.chan)
        report($sformatf("channel %0d, predicted %0d (byte %02h)", ch, want.chan, want.data));
      if (oc !== want.oc)
        report($sformatf("outcome %0d, predicted %0d (byte %02h)", oc, want.oc, want.data));
      if (lst !== want.lst)
        report($sformatf("last %0d, predicted %0d (byte %02h)", lst, want.lst, want.data));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       op;
  logic [7:0] byte_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       channel;
  logic [1:0] outcome;
  logic       last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] capacity;

  redraw_tracker tracker;
  bit gaps_on;
  bit stall_on;
  int stall_left;
  int items_sent;

  terminal_line_editor dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .channel    (channel),
    .outcome    (outcome),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= stall_on;
    end else begin
      out_stall <= 1'b0;
      if (stall_on) stall_left = pick_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_echo(out_byte, channel, outcome, last);
  end

  // one input transaction, entered and left at a falling edge
  task automatic push_key(input logic key_op, input logic [7:0] key_byte);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= key_op;
    byte_value <= key_byte;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_keystroke(key_op, key_byte);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_key(tle_pkg::OP_BYTE, b);
  endtask

  task automatic push_arrow(input logic [7:0] dir);
    push_byte(tle_pkg::CH_ESC);
    push_byte(tle_pkg::CH_LBRACKET);
    push_byte(dir);
  endtask

  // wait for every predicted byte, then let the block finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [5:0] v);
    cfg_valid <= 1'b1;
    capacity  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // byte outside the printable range that the editor drops without echo
  function automatic logic [7:0] ignored_byte();
    logic [7:0] v;
    if ($urandom_range(0, 1)) return 8'($urandom_range(128, 255));
    do v = 8'($urandom_range(0, 31));
    while (v == tle_pkg::CH_BS || v == tle_pkg::CH_LF || v == tle_pkg::CH_CR
           || v == tle_pkg::CH_ESC);
    return v;
  endfunction

  // silence now and then, otherwise a random byte
  task automatic push_noise(input int silence_one_in);
    push_key(($urandom_range(0, silence_one_in - 1) == 0) ? tle_pkg::OP_SILENCE
                                                           : tle_pkg::OP_BYTE,
             8'($urandom));
  endtask

  // mostly editing keys and arrows, some noise and broken escapes
  task automatic send_random_edit(input int accept_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      push_byte(8'($urandom_range(32, 126)));
    end else if (r < 58) begin
      push_byte($urandom_range(0, 1) ? tle_pkg::CH_DEL : tle_pkg::CH_BS);
    end else if (r < 72) begin
      push_arrow($urandom_range(0, 1) ? tle_pkg::CH_C : tle_pkg::CH_D);
    end else if (r < 72 + accept_pct) begin
      case ($urandom_range(0, 2))
        0: push_byte(tle_pkg::CH_CR);
        1: push_byte(tle_pkg::CH_LF);
        default: push_key(tle_pkg::OP_SILENCE, 8'($urandom));
      endcase
    end else if (r < 78 + accept_pct) begin
      push_byte(ignored_byte());
    end else if (r < 83 + accept_pct) begin
      push_byte(tle_pkg::CH_ESC);
      if ($urandom_range(0, 1)) begin
        push_noise(4);
      end else begin
        push_byte(tle_pkg::CH_LBRACKET);
        push_noise(4);
      end
    end else begin
      push_noise(5);
    end
  endtask

  // stimulus
  initial begin
    logic [5:0] cap_plan [10];
    logic [5:0] cap;
    int p;
    int n;

    cap_plan = '{6'd32, 6'd1, 6'd63, 6'd2, 6'd17, 6'd0, 6'd0, 6'd31, 6'd5, 6'd0};
    tracker    = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = tle_pkg::OP_BYTE;
    byte_value = 8'h00;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    capacity   = tle_pkg::CAP_RESET;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    stall_left = 0;
    items_sent = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // above the top of the range, saturates to the full buffer
    write_capacity(6'd63);

    // directed editing
    push_key(tle_pkg::OP_SILENCE, 8'hff);
    push_byte(tle_pkg::CH_SPACE);
    push_byte("~");
    push_arrow(tle_pkg::CH_D);
    push_byte("x");
    push_arrow(tle_pkg::CH_C);
    push_arrow(tle_pkg::CH_C);
    push_byte(tle_pkg::CH_DEL);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(tle_pkg::CH_CR);
    push_byte(tle_pkg::CH_BS);
    push_byte(tle_pkg::CH_ESC);
    push_byte("Q");
    push_byte(tle_pkg::CH_ESC);
    push_key(tle_pkg::OP_SILENCE, 8'h00);
    push_byte(tle_pkg::CH_ESC);
    push_byte(tle_pkg::CH_LBRACKET);
    push_key(tle_pkg::OP_SILENCE, 8'h00);
    push_byte(tle_pkg::CH_LF);

    // full line refuses inserts, then capacity drops below the length
    settle();
    write_capacity(6'd3);
    push_byte("a");
    push_byte("b");
    push_byte("c");
    settle();
    write_capacity(6'd0);
    push_byte("d");
    push_byte(tle_pkg::CH_CR);

    // random phases over a spread of capacities
    p = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      cap = (p % 10 == 6 || p % 10 == 9) ? 6'($urandom) : cap_plan[p % 10];
      write_capacity(cap);
      gaps_on  = (p % 4 != 1);
      stall_on = (p % 4 != 1);
      for (n = 0; n < 45 && items_sent < ITEM_TARGET; n++) begin
        // sender holds off until the result side has caught up
        if (p == 2 && n == 20) settle();
        send_random_edit((p % 3 == 0) ? 2 : 9);
      end
      p++;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
